@@ design/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int SOURCES = 16;
  localparam int SRC_W   = $clog2(SOURCES);
  localparam int CNT_W   = $clog2(SOURCES + 1);
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 32;

  // configuration register indexes
  localparam logic CFG_DESCENDING = 1'b0;
  localparam logic CFG_ACTIVE     = 1'b1;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } head_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [SRC_W-1:0] idx;
  } cmp_ctrl_t;

  // current winner held by the compare unit
  typedef struct packed {
    logic [SRC_W-1:0] idx;
    head_t            head;
  } best_t;

endpackage

@@ design/kwm_if.sv @@
// ----------------------------------------------------------------------------
// kwm_in_if / kwm_out_if
// Valid/ready channels for source records and merge results.
// ----------------------------------------------------------------------------
interface kwm_in_if;
  logic                      valid;
  logic                      ready;
  logic [kwm_pkg::SRC_W-1:0] source_index;
  logic [kwm_pkg::KEY_W-1:0] record_key;
  logic [kwm_pkg::PAY_W-1:0] record_payload;
  logic                      source_ended;

  modport source (output valid, source_index, record_key, record_payload, source_ended,
                  input ready);
  modport sink   (input valid, source_index, record_key, record_payload, source_ended,
                  output ready);
endinterface

interface kwm_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [kwm_pkg::SRC_W-1:0] from_source;
  logic [kwm_pkg::KEY_W-1:0] out_key;
  logic [kwm_pkg::PAY_W-1:0] out_payload;

  modport source (output valid, result_kind, from_source, out_key, out_payload,
                  input ready);
  modport sink   (input valid, result_kind, from_source, out_key, out_payload,
                  output ready);
endinterface

@@ design/kwm_head_ram.sv @@
// ----------------------------------------------------------------------------
// kwm_head_ram
// Head record store, one entry per source, registered read.
// ----------------------------------------------------------------------------
module kwm_head_ram (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [kwm_pkg::SRC_W-1:0] wr_addr,
  input  kwm_pkg::head_t        wr_data,
  input  logic [kwm_pkg::SRC_W-1:0] rd_addr,
  output kwm_pkg::head_t        rd_data
);
  import kwm_pkg::*;

  head_t mem [SOURCES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/kwm_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// kwm_cmp_unit
// Shared key comparator; keeps the running winner of a scan.
// ----------------------------------------------------------------------------
module kwm_cmp_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  kwm_pkg::cmp_ctrl_t  ctrl,
  input  logic                descending,
  input  kwm_pkg::head_t      rd_data,
  output kwm_pkg::best_t      best
);
  import kwm_pkg::*;

  logic  have_r, have_nxt;
  best_t best_r, best_nxt;
  logic  better;
  logic  take;

  // strict compare: ties keep the lower index seen first
  assign better = descending ? (rd_data.key > best_r.head.key)
                             : (rd_data.key < best_r.head.key);
  assign take   = ctrl.valid && (!have_r || better);

  always_comb begin
    have_nxt = have_r;
    best_nxt = best_r;
    if (ctrl.clear) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt      = 1'b1;
      best_nxt.idx  = ctrl.idx;
      best_nxt.head = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
    best_r <= best_nxt;
  end

  assign best = best_r;

endmodule

@@ design/k_way_merge_engine.sv @@
// ----------------------------------------------------------------------------
// k_way_merge_engine
// An error item goes straight to the output register, end of merge after the
// evaluation of the flags, and a merged record after a scan of the active
// sources. One item at a time: the next item is accepted only once the last
// one is through, and an item with a result also waits while the output
// register stays full. The rate is set by the scan of the head store through
// one comparator, one source per cycle. Reset (synchronous, rst_n low) clears
// all head flags, end marks and the merge-finished flag; descending = 0,
// active count = 16.
// ----------------------------------------------------------------------------
module k_way_merge_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  kwm_in_if.sink                    in_ch,
  kwm_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [kwm_pkg::CNT_W-1:0] cfg_wdata
);
  import kwm_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic             desc_r;
  logic [CNT_W-1:0] active_r;
  logic [CNT_W-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r   <= 1'b0;
      active_r <= CNT_W'(SOURCES);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DESCENDING: desc_r   <= cfg_wdata[0];
        CFG_ACTIVE:     active_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // zero acts as one, anything above the source count as the source count
  always_comb begin
    n_eff = active_r;
    if (active_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_r > CNT_W'(SOURCES)) begin
      n_eff = CNT_W'(SOURCES);
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  // latched input item
  logic [SRC_W-1:0] item_src_r;
  head_t            item_head_r;
  logic             item_end_r;

  // per-source flags
  logic [SOURCES-1:0] pres_r, pres_nxt;
  logic [SOURCES-1:0] fin_r, fin_nxt;
  logic               merge_fin_r, merge_fin_nxt;

  // scan sequencer
  logic [SRC_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issue_vld_r;
  logic [SRC_W-1:0] issue_idx_r;

  // pending result
  kind_t res_kind_r, res_kind_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r;
  logic [SRC_W-1:0] out_src_r;
  head_t            out_head_r;

  // --------------------------------------------------------------------------
  // Flag decode
  // --------------------------------------------------------------------------
  logic [SOURCES-1:0] act_mask;
  logic               item_err;
  logic               all_ended;
  logic               all_ready;
  logic               scan_last;
  logic               out_free;
  logic               load_out;

  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      act_mask[i] = (CNT_W'(i) < n_eff);
    end
  end

  // source not awaited: out of range, already has a head, already ended,
  // or the merge is over
  assign item_err  = merge_fin_r || ({1'b0, item_src_r} >= n_eff) ||
                     pres_r[item_src_r] || fin_r[item_src_r];
  assign all_ended = &(fin_r | ~act_mask);
  assign all_ready = &(fin_r | pres_r | ~act_mask);
  assign scan_last = ({1'b0, scan_idx_r} == (n_eff - CNT_W'(1)));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load_out  = (state_r == ST_RESULT) && out_free;

  // --------------------------------------------------------------------------
  // Head store and shared comparator
  // --------------------------------------------------------------------------
  logic      ram_we;
  head_t     ram_rd;
  cmp_ctrl_t cmp_ctrl;
  best_t     best;

  assign ram_we = (state_r == ST_CHECK) && !item_err && !item_end_r;

  kwm_head_ram u_head_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (item_src_r),
    .wr_data (item_head_r),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rd)
  );

  // the read issued last cycle returns now; ended sources are skipped
  assign cmp_ctrl.clear = (state_r == ST_EVAL);
  assign cmp_ctrl.valid = issue_vld_r && !fin_r[issue_idx_r];
  assign cmp_ctrl.idx   = issue_idx_r;

  kwm_cmp_unit u_cmp_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (cmp_ctrl),
    .descending (desc_r),
    .rd_data    (ram_rd),
    .best       (best)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = item_err ? ST_RESULT : ST_EVAL;
      end
      ST_EVAL: begin
        if (all_ended) begin
          state_nxt = ST_RESULT;
        end else if (all_ready) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    pres_nxt      = pres_r;
    fin_nxt       = fin_r;
    merge_fin_nxt = merge_fin_r;
    scan_idx_nxt  = scan_idx_r;
    res_kind_nxt  = res_kind_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CHECK: begin
        if (item_err) begin
          res_kind_nxt = KIND_ERROR;
        end else if (item_end_r) begin
          fin_nxt[item_src_r] = 1'b1;
        end else begin
          pres_nxt[item_src_r] = 1'b1;
        end
      end
      ST_EVAL: begin
        scan_idx_nxt = '0;
        if (all_ended) begin
          merge_fin_nxt = 1'b1;
          res_kind_nxt  = KIND_END;
        end else begin
          res_kind_nxt  = KIND_RECORD;
        end
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + SRC_W'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          // the winner's source is awaited again
          if (res_kind_r == KIND_RECORD) begin
            pres_nxt[best.idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pres_r      <= '0;
      fin_r       <= '0;
      merge_fin_r <= 1'b0;
      issue_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pres_r      <= pres_nxt;
      fin_r       <= fin_nxt;
      merge_fin_r <= merge_fin_nxt;
      issue_vld_r <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r  <= scan_idx_nxt;
    issue_idx_r <= scan_idx_r;
    res_kind_r  <= res_kind_nxt;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_src_r       <= in_ch.source_index;
      item_head_r.key  <= in_ch.record_key;
      item_head_r.pay  <= in_ch.record_payload;
      item_end_r       <= in_ch.source_ended;
    end
  end

  // result payload; non-record kinds carry zero key and payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r <= res_kind_r;
      case (res_kind_r)
        KIND_RECORD: begin
          out_src_r  <= best.idx;
          out_head_r <= best.head;
        end
        KIND_ERROR: begin
          out_src_r  <= item_src_r;
          out_head_r <= '0;
        end
        default: begin
          out_src_r  <= '0;
          out_head_r <= '0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.from_source = out_src_r;
  assign out_ch.out_key     = out_head_r.key;
  assign out_ch.out_payload = out_head_r.pay;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a source never holds a head after its end mark
  a_flags_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (pres_r & fin_r) == '0)
    else $error("source both holds a head and has ended");

  // the emitted winner must be a source that holds a head
  a_winner_present: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && res_kind_r == KIND_RECORD |-> pres_r[best.idx] && !fin_r[best.idx])
    else $error("merged record taken from a source without a head");

  // end of merge is queued for output as soon as the finished flag rises
  a_end_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(merge_fin_r) |-> state_r == ST_RESULT && res_kind_r == KIND_END)
    else $error("end of merge not reported");

endmodule

@@ test/tb_k_way_merge_engine.sv @@
// ----------------------------------------------------------------------------
// tb_k_way_merge_engine
// Self-checking bench for the k-way merge engine. Record items go in over a
// valid/ready channel, in bursts with random gaps, while the result channel
// stalls on its own pattern. A scoreboard class keeps its own copy of the
// head store and of the registers, predicts the result of every accepted
// item and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_k_way_merge_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYC = 40;   // idle time after the last expected result
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [3:0]  src;
    logic [31:0] key;
    logic [31:0] pay;
    logic        ended;
  } record_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  src;
    logic [31:0] key;
    logic [31:0] pay;
  } merge_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the heads, end marks and registers
  // --------------------------------------------------------------------------
  class merge_scoreboard;
    logic [31:0]      head_key [SOURCES];
    logic [31:0]      head_pay [SOURCES];
    bit               head_vld [SOURCES];
    bit               src_done [SOURCES];
    bit               merge_done;
    bit               desc;
    logic [CNT_W-1:0] act_reg;
    merge_out_t       merge_out_q[$];
    int               n_fail;

    function new();
      for (int i = 0; i < SOURCES; i++) begin
        head_key[i] = '0;
        head_pay[i] = '0;
        head_vld[i] = 1'b0;
        src_done[i] = 1'b0;
      end
      merge_done = 1'b0;
      desc       = 1'b0;
      act_reg    = CNT_W'(SOURCES);
      n_fail     = 0;
    endfunction

    function void write_reg(logic idx, logic [CNT_W-1:0] val);
      if (idx == CFG_DESCENDING) desc = val[0];
      else act_reg = val;
    endfunction

    // 0 counts as one source, anything above SOURCES as SOURCES
    function int live_count();
      int n;
      n = act_reg;
      if (n == 0) n = 1;
      if (n > SOURCES) n = SOURCES;
      return n;
    endfunction

    function bit awaited(int s);
      return !merge_done && s < live_count() && !head_vld[s] && !src_done[s];
    endfunction

    // accepted record: update the heads and queue the result it causes
    function void take_record(record_t rec);
      int         n;
      int         best;
      bit         have;
      merge_out_t r;
      n = live_count();
      r = '0;
      if (!awaited(rec.src)) begin
        r.kind = KIND_ERROR;
        r.src  = rec.src;
        merge_out_q.push_back(r);
        return;
      end
      if (rec.ended) begin
        src_done[rec.src] = 1'b1;
      end else begin
        head_key[rec.src] = rec.key;
        head_pay[rec.src] = rec.pay;
        head_vld[rec.src] = 1'b1;
      end
      have = 1'b0;
      best = 0;
      // strict compare: equal keys stay with the lower index
      for (int i = 0; i < n; i++) begin
        if (src_done[i]) continue;
        if (!head_vld[i]) return;   // still waiting for a head
        if (!have || (desc ? head_key[i] > head_key[best]
                           : head_key[i] < head_key[best])) begin
          best = i;
          have = 1'b1;
        end
      end
      if (!have) begin
        merge_done = 1'b1;
        r.kind = KIND_END;
        merge_out_q.push_back(r);
        return;
      end
      head_vld[best] = 1'b0;
      r.kind = KIND_RECORD;
      r.src  = best[3:0];
      r.key  = head_key[best];
      r.pay  = head_pay[best];
      merge_out_q.push_back(r);
    endfunction

    function void flag(string what, merge_out_t want, merge_out_t got);
      n_fail++;
      if (n_fail <= MAX_REPORT) begin
        $display("%0t %s: expected kind %0d src %0d key %h pay %h",
                 $time, what, want.kind, want.src, want.key, want.pay);
        $display("%0t %s: actual   kind %0d src %0d key %h pay %h",
                 $time, what, got.kind, got.src, got.key, got.pay);
      end
    endfunction

    function void check_merge_out(merge_out_t got);
      merge_out_t want;
      if (merge_out_q.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = merge_out_q.pop_front();
      if (got.kind !== want.kind || got.src !== want.src ||
          got.key !== want.key || got.pay !== want.pay)
        flag("result mismatch", want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  merge_scoreboard sb;
  int              results_seen = 0;
  bit              held_off = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  k_way_merge_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_record(logic [3:0] src, logic [31:0] key, logic [31:0] pay,
                             logic ended);
    record_t rec;
    rec = '{src: src, key: key, pay: pay, ended: ended};
    in_ch.valid          <= 1'b1;
    in_ch.source_index   <= src;
    in_ch.record_key     <= key;
    in_ch.record_payload <= pay;
    in_ch.source_ended   <= ended;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_record(rec);
  endtask

  task automatic pause(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender idle until every expected result is out, then let the block settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.merge_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // both registers, one write per edge; only called while the block is idle
  task automatic set_config(bit d, logic [CNT_W-1:0] act);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DESCENDING;
    cfg_wdata <= CNT_W'(d);
    @(posedge clk);
    sb.write_reg(CFG_DESCENDING, CNT_W'(d));
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= act;
    @(posedge clk);
    sb.write_reg(CFG_ACTIVE, act);
    cfg_we <= 1'b0;
  endtask

  // small keys give plenty of ties, plus the two key extremes
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 7));
      default: return 32'($urandom);
    endcase
  endfunction

  // mostly the next record of an awaited source; the rest is noise.
  // Sources 0..7 never end here, so the merge stays alive until the end.
  task automatic pick_record(output record_t rec, output bit clean);
    int cand[$];
    int s;
    for (int i = 0; i < SOURCES; i++)
      if (sb.awaited(i)) cand.push_back(i);
    if (cand.size() == 0 || $urandom_range(0, 99) < 12) begin
      rec.src   = 4'($urandom_range(0, 15));
      rec.key   = 32'($urandom);
      rec.pay   = 32'($urandom);
      rec.ended = 1'($urandom_range(0, 1));
      clean     = sb.awaited(rec.src);
      if (clean) rec.ended = 1'b0;
    end else begin
      s         = cand[$urandom_range(0, cand.size() - 1)];
      rec.src   = 4'(s);
      rec.key   = rand_key();
      rec.pay   = 32'($urandom);
      rec.ended = (s >= 8) && ($urandom_range(0, 99) < 3);
      clean     = 1'b1;
    end
  endtask

  task automatic run_phase(int n_clean);
    int      good;
    int      noise;
    int      burst;
    record_t rec;
    bit      clean;
    good  = 0;
    noise = 0;
    while (good < n_clean && noise < 40) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (good >= n_clean || noise >= 40) break;
        pick_record(rec, clean);
        send_record(rec.src, rec.key, rec.pay, rec.ended);
        if (clean) good++;
        else noise++;
      end
      // a quarter of the bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
    end
  endtask

  // end every source, mixing in a few last records, until end of merge
  task automatic finish_merge();
    int cand[$];
    int s;
    int guard;
    guard = 0;
    while (!sb.merge_done && guard < 500) begin
      guard++;
      cand.delete();
      for (int i = 0; i < SOURCES; i++)
        if (sb.awaited(i)) cand.push_back(i);
      if (cand.size() == 0) break;
      s = cand[$urandom_range(0, cand.size() - 1)];
      if ($urandom_range(0, 99) < 15)
        send_record(4'(s), rand_key(), 32'($urandom), 1'b0);
      else
        send_record(4'(s), 32'($urandom), 32'($urandom), 1'b1);
      if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 10));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int act_plan [10] = '{16, 1, 31, 8, 0, 5, 12, 17, 2, 16};
    sb = new();
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_DESCENDING;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.source_index   <= '0;
    in_ch.record_key     <= '0;
    in_ch.record_payload <= '0;
    in_ch.source_ended   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed: single source, key/payload extremes, sources past the count
    set_config(1'b0, CNT_W'(1));
    send_record(4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0);
    send_record(4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_record(4'd1,  32'h0000_0005, 32'h1234_5678, 1'b0);  // beyond count
    send_record(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // beyond count
    settle();

    // two sources: waiting for a head, head already held, tie, ascending pick
    set_config(1'b0, CNT_W'(2));
    send_record(4'd0, 32'd100, 32'hAAAA_0000, 1'b0);  // waits for source 1
    send_record(4'd0, 32'd7,   32'hDEAD_BEEF, 1'b0);  // head held: error
    send_record(4'd1, 32'd100, 32'h5555_0001, 1'b0);  // tie, lower index wins
    send_record(4'd0, 32'd50,  32'hAAAA_0002, 1'b0);
    send_record(4'd0, 32'hFFFF_FFFF, 32'hAAAA_0003, 1'b0);
    settle();

    // direction flipped mid-merge
    set_config(1'b1, CNT_W'(2));
    send_record(4'd1, 32'd3, 32'h5555_0004, 1'b0);
    send_record(4'd0, 32'd3, 32'hAAAA_0005, 1'b0);
    send_record(4'd0, 32'd0, 32'hAAAA_0006, 1'b0);
    settle();

    // count 0 acts as one: nothing left to await
    set_config(1'b1, CNT_W'(0));
    send_record(4'd0, 32'd1, 32'h0000_0001, 1'b0);
    send_record(4'd1, 32'd1, 32'h0000_0002, 1'b0);
    settle();

    // count grown mid-merge; a source ends, then sends again
    set_config(1'b1, CNT_W'(3));
    send_record(4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_record(4'd2, 32'd1, 32'h0000_0003, 1'b0);       // already ended
    send_record(4'd1, 32'd9, 32'h5555_0007, 1'b0);
    settle();

    // -- random phases, one register setting each, extremes and out of range
    for (int p = 0; p < 10; p++) begin
      set_config((p < 4) ? p[0] : 1'($urandom_range(0, 1)), CNT_W'(act_plan[p]));
      run_phase(80);
      settle();
    end

    // -- all sources end, then end of merge, then only errors
    set_config(1'($urandom_range(0, 1)), CNT_W'(SOURCES));
    finish_merge();
    send_record(4'd0,  32'($urandom), 32'($urandom), 1'b0);
    send_record(4'd15, 32'($urandom), 32'($urandom), 1'b1);
    send_record(4'd7,  32'($urandom), 32'($urandom), 1'b0);
    settle();

    sb.n_fail += sb.merge_out_q.size();
    if (sb.n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off so the block
  // backs up and stalls its input while the sender keeps offering
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int len;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(4, 40);
        repeat (len) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      merge_out_t got;
      got.kind = out_ch.result_kind;
      got.src  = out_ch.from_source;
      got.key  = out_ch.out_key;
      got.pay  = out_ch.out_payload;
      sb.check_merge_out(got);
      results_seen++;
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
